### src/qoi_dec_pkg.sv
// ----------------------------------------------------------------------------
// QOI decoder package
// Shared types and constants for the QOI stream decoder.
// ----------------------------------------------------------------------------
package qoi_dec_pkg;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HDR_OK = 2'd1;
  localparam logic [1:0] KIND_HDR_BAD = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_MAGIC    = 2'd1;
  localparam logic [1:0] ERR_DIM      = 2'd2;
  localparam logic [1:0] ERR_CHANNELS = 2'd3;

  localparam logic [7:0] OP_RGB  = 8'hFE;
  localparam logic [7:0] OP_RGBA = 8'hFF;
  localparam logic [1:0] TAG_INDEX = 2'd0;
  localparam logic [1:0] TAG_DIFF  = 2'd1;
  localparam logic [1:0] TAG_LUMA  = 2'd2;
  localparam logic [1:0] TAG_RUN   = 2'd3;

  localparam int unsigned HeaderBytes = 14;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [14:0] image_width;
    logic [14:0] image_height;
    logic [7:0]  file_channels;
    logic [1:0]  error_code;
    logic        last_of_run;
    logic        image_done;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } item_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;       // reset image state (with the accepted byte)
    logic take_byte;   // apply the accepted byte
    logic index_done;  // color index read data is ready, finish the chunk
    logic emit;        // emit one pixel of the current chunk
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hdr_result;  // the accepted byte produced a header result
    logic chunk_done;  // the accepted byte completed a chunk
    logic idx_lookup;  // the accepted byte started a color index read
    logic last_pixel;  // pending pixel is the last for this chunk
  } dp_status_t;

endpackage

### src/qoi_dec_if.sv
// ----------------------------------------------------------------------------
// QOI decoder channel interfaces
// Valid/ready channels for input bytes, results and configuration.
// ----------------------------------------------------------------------------
interface qoi_dec_in_if;
  logic                valid;
  logic                ready;
  qoi_dec_pkg::item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface qoi_dec_out_if;
  logic                  valid;
  logic                  ready;
  qoi_dec_pkg::result_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface qoi_dec_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/qoi_image_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// QOI image stream decoder
// Decodes a QOI byte stream into a header result and RGBA pixels.
// ----------------------------------------------------------------------------
// One compressed byte is taken per cycle while the result register is free;
// a byte that completes a chunk stalls the input while its pixels are emitted
// (1 for most chunks, up to 62 for a run) by the pixel emitter that drains
// the result register once per cycle while the downstream is ready, and also
// while the downstream holds ready low. An index byte first waits on the
// registered read of the 64-entry color index before its pixel is known. The
// color index has per-entry valid bits, so a new image needs no clearing pass.
module qoi_image_stream_decoder_core #(
  parameter int unsigned MaxDimension = 16384
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  qoi_dec_in_if.sink            in_ch,
  qoi_dec_out_if.source         out_ch,
  qoi_dec_cfg_if.sink           cfg_ch
);

  logic [31:0]             stream_length_q;
  qoi_dec_pkg::dp_cmd_t    cmd;
  qoi_dec_pkg::dp_status_t status;
  qoi_dec_pkg::result_t    res, res_q;
  logic                    res_load, out_valid_q, out_free;

  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_q || out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_length_q <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_ch.valid) stream_length_q <= cfg_ch.payload;
      if (out_free) out_valid_q <= res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) res_q <= res;
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.payload = res_q;

  qoi_dec_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_ch.valid),
    .in_sos_i   (in_ch.payload.start_of_image),
    .in_ready_o (in_ch.ready),
    .res_load_o (res_load),
    .out_free_i (out_free),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  qoi_dec_dp #(.MaxDimension(MaxDimension)) u_dp (
    .clk_i,
    .rst_ni,
    .stream_length_i (stream_length_q),
    .byte_i          (in_ch.payload.data_byte),
    .cmd_i           (cmd),
    .status_o        (status),
    .res_o           (res)
  );

endmodule

### src/qoi_dec_ctrl.sv
// ----------------------------------------------------------------------------
// QOI decoder controller
// Handshake sequencing: takes bytes, waits on a color index read, then emits
// a chunk's pixels one per cycle while the result register is free.
// ----------------------------------------------------------------------------
module qoi_dec_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_sos_i,
  output logic                    in_ready_o,
  output logic                    res_load_o,
  input  logic                    out_free_i,
  output qoi_dec_pkg::dp_cmd_t    cmd_o,
  input  qoi_dec_pkg::dp_status_t status_i
);

  localparam logic [1:0] ST_TAKE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       take;

  assign in_ready_o = (state_q == ST_TAKE) && out_free_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.start      = take && in_sos_i;
    cmd_o.take_byte  = take;
    cmd_o.index_done = (state_q == ST_LOOK);
    cmd_o.emit       = (state_q == ST_EMIT) && out_free_i;
    res_load_o       = (take && status_i.hdr_result) || cmd_o.emit;
    state_d          = state_q;
    unique case (state_q)
      ST_TAKE: begin
        if (take && status_i.chunk_done) begin
          state_d = ST_EMIT;
        end else if (take && status_i.idx_lookup) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: state_d = ST_EMIT;
      ST_EMIT: if (cmd_o.emit && status_i.last_pixel) state_d = ST_TAKE;
      default: state_d = ST_TAKE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_TAKE;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_TAKE |-> !in_ready_o) else $error("input taken during run");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !cmd_o.take_byte) else $error("emit overlaps byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |-> out_free_i) else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.index_done |-> !cmd_o.take_byte && !cmd_o.emit)
    else $error("index read overlaps byte or pixel");

endmodule

### src/qoi_dec_dp.sv
// ----------------------------------------------------------------------------
// QOI decoder datapath
// Header parse, chunk decode, color index memory and pixel counters.
// ----------------------------------------------------------------------------
module qoi_dec_dp #(
  parameter int unsigned MaxDimension = 16384
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [31:0]             stream_length_i,
  input  logic [7:0]              byte_i,
  input  qoi_dec_pkg::dp_cmd_t    cmd_i,
  output qoi_dec_pkg::dp_status_t status_o,
  output qoi_dec_pkg::result_t    res_o
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_OPCODE = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;
  localparam logic [1:0] PH_IDLE   = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [31:0] seen_q, seen_d;
  logic [31:0] left_q, left_d;
  logic [31:0] px_q, px_d;          // r,g,b,a from msb
  logic [7:0]  op_q, op_d;
  logic [2:0]  cbl_q, cbl_d;
  logic [5:0]  run_q, run_d;        // remaining copies minus one
  logic [63:0] idx_valid_q, idx_valid_d;
  logic [31:0] idx_mem [64];
  logic [31:0] idx_rd_q;
  logic        idx_hit_q;
  logic [7:0]  hdr_q [13];
  logic        chunk_done;
  logic        lookup;

  // Effective state after an optional start of image.
  logic [1:0]  ph;
  logic [31:0] pos;
  logic [31:0] px;
  logic [63:0] iv;
  logic [2:0]  cbl;

  logic [31:0] w32, h32;
  logic [1:0]  err;
  logic [7:0]  r, g, b, a, vg;
  logic [5:0]  hash;
  logic        hdr_now;
  logic [5:0]  run_len;

  assign ph  = cmd_i.start ? PH_HEADER : phase_q;
  assign pos = cmd_i.start ? 32'd0 : seen_q;
  assign px  = cmd_i.start ? 32'h0000_00FF : px_q;
  assign iv  = cmd_i.start ? 64'd0 : idx_valid_q;
  assign cbl = cmd_i.start ? 3'd0 : cbl_q;

  assign w32 = {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]};
  assign h32 = {hdr_q[8], hdr_q[9], hdr_q[10], hdr_q[11]};
  assign hdr_now = (ph == PH_HEADER) && (pos == 32'(qoi_dec_pkg::HeaderBytes - 1));

  always_comb begin
    if ({hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3]} != 32'h716F6966) begin
      err = qoi_dec_pkg::ERR_MAGIC;
    end else if (w32 == 32'd0 || h32 == 32'd0 || w32 > 32'(MaxDimension)
                 || h32 > 32'(MaxDimension)) begin
      err = qoi_dec_pkg::ERR_DIM;
    end else if (hdr_q[12] != 8'd3 && hdr_q[12] != 8'd4) begin
      err = qoi_dec_pkg::ERR_CHANNELS;
    end else begin
      err = qoi_dec_pkg::ERR_NONE;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    seen_d      = seen_q;
    left_d      = left_q;
    px_d        = px_q;
    op_d        = op_q;
    cbl_d       = cbl_q;
    run_d       = run_q;
    idx_valid_d = idx_valid_q;
    chunk_done  = 1'b0;
    lookup      = 1'b0;
    {r, g, b, a} = px;
    vg      = 8'd0;
    run_len = 6'd0;
    if (cmd_i.take_byte) begin
      phase_d = ph;
      left_d  = cmd_i.start ? 32'd0 : left_q;
      op_d    = cmd_i.start ? 8'd0 : op_q;
      cbl_d   = cbl;
      idx_valid_d = iv;
      seen_d  = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
      unique case (ph)
        PH_HEADER: begin
          if (hdr_now) begin
            if (err != qoi_dec_pkg::ERR_NONE) begin
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_OPCODE;
              left_d  = {16'd0, w32[15:0]} * {16'd0, h32[15:0]};
            end
          end
        end
        PH_OPCODE: begin
          if ({1'b0, pos} + 33'd8 >= {1'b0, stream_length_i}) begin
            phase_d = PH_IDLE;
          end else begin
            op_d = byte_i;
            if (byte_i == qoi_dec_pkg::OP_RGB || byte_i == qoi_dec_pkg::OP_RGBA) begin
              cbl_d   = (byte_i == qoi_dec_pkg::OP_RGB) ? 3'd3 : 3'd4;
              phase_d = PH_BODY;
            end else begin
              unique case (byte_i[7:6])
                qoi_dec_pkg::TAG_INDEX: lookup = 1'b1;
                qoi_dec_pkg::TAG_DIFF: begin
                  r = px[31:24] + {6'd0, byte_i[5:4]} - 8'd2;
                  g = px[23:16] + {6'd0, byte_i[3:2]} - 8'd2;
                  b = px[15:8]  + {6'd0, byte_i[1:0]} - 8'd2;
                end
                qoi_dec_pkg::TAG_LUMA: begin
                  cbl_d   = 3'd1;
                  phase_d = PH_BODY;
                end
                qoi_dec_pkg::TAG_RUN: run_len = byte_i[5:0];
                default: ;
              endcase
              chunk_done = (byte_i[7:6] == qoi_dec_pkg::TAG_DIFF)
                           || (byte_i[7:6] == qoi_dec_pkg::TAG_RUN);
            end
          end
        end
        PH_BODY: begin
          if (op_q == qoi_dec_pkg::OP_RGB || op_q == qoi_dec_pkg::OP_RGBA) begin
            unique case ((((op_q == qoi_dec_pkg::OP_RGB) ? 3'd3 : 3'd4) - cbl) & 3'd3)
              3'd0: r = byte_i;
              3'd1: g = byte_i;
              3'd2: b = byte_i;
              default: a = byte_i;
            endcase
          end else begin
            vg = {2'b0, op_q[5:0]} - 8'd32;
            r = px[31:24] + vg - 8'd8 + {4'd0, byte_i[7:4]};
            g = px[23:16] + vg;
            b = px[15:8]  + vg - 8'd8 + {4'd0, byte_i[3:0]};
          end
          cbl_d = (cbl > 3'd0) ? cbl - 3'd1 : cbl;
          chunk_done = (cbl_d == 3'd0);
        end
        default: ;
      endcase
      px_d = {r, g, b, a};
    end
    // The indexed color, read from the memory with its byte, is used in the cycle after that byte.
    if (cmd_i.index_done) begin
      {r, g, b, a} = idx_hit_q ? idx_rd_q : 32'd0;
      px_d       = {r, g, b, a};
      chunk_done = 1'b1;
    end
    if (chunk_done) begin
      phase_d = PH_BODY;  // held until the run ends
      run_d   = (32'(run_len) + 32'd1 < left_d) ? run_len : 6'(left_d - 32'd1);
      idx_valid_d[hash] = 1'b1;
    end
    if (cmd_i.emit) begin
      left_d = left_q - 32'd1;
      run_d  = run_q - 6'd1;
      if (run_q == 6'd0) phase_d = (left_q == 32'd1) ? PH_IDLE : PH_OPCODE;
    end
  end

  assign hash = 6'({r, 1'b0} + {2'b0, r} + {g, 2'b0} + {2'b0, g}
                  + {b, 3'b0} - {3'b0, b} + {a, 3'b0} + {2'b0, a, 1'b0} + {3'b0, a});

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && ph == PH_HEADER && pos < 32'd13) hdr_q[pos[3:0]] <= byte_i;
    if (chunk_done) idx_mem[hash] <= {r, g, b, a};
    if (lookup) begin
      idx_rd_q  <= idx_mem[byte_i[5:0]];
      idx_hit_q <= iv[byte_i[5:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      seen_q      <= '0;
      left_q      <= '0;
      px_q        <= 32'h0000_00FF;
      op_q        <= '0;
      cbl_q       <= '0;
      run_q       <= '0;
      idx_valid_q <= '0;
    end else begin
      phase_q     <= phase_d;
      seen_q      <= seen_d;
      left_q      <= left_d;
      px_q        <= px_d;
      op_q        <= op_d;
      cbl_q       <= cbl_d;
      run_q       <= run_d;
      idx_valid_q <= idx_valid_d;
    end
  end

  assign status_o.hdr_result = hdr_now;
  assign status_o.chunk_done = chunk_done;
  assign status_o.idx_lookup = lookup;
  assign status_o.last_pixel = (run_q == 6'd0);

  always_comb begin
    res_o = '0;
    if (cmd_i.emit) begin
      {res_o.red, res_o.green, res_o.blue, res_o.alpha} = px_q;
      res_o.kind        = qoi_dec_pkg::KIND_PIXEL;
      res_o.last_of_run = (run_q == 6'd0);
      res_o.image_done  = (left_q == 32'd1);
    end else begin
      res_o.file_channels = hdr_q[12];
      res_o.error_code    = err;
      res_o.last_of_run   = 1'b1;
      if (err == qoi_dec_pkg::ERR_NONE) begin
        res_o.kind         = qoi_dec_pkg::KIND_HDR_OK;
        res_o.image_width  = w32[14:0];
        res_o.image_height = h32[14:0];
      end else begin
        res_o.kind = qoi_dec_pkg::KIND_HDR_BAD;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> left_q != 32'd0) else $error("pixel emitted past image end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> {26'd0, run_q} < left_q) else $error("run exceeds pixels left");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_done |-> cmd_i.take_byte || cmd_i.index_done)
    else $error("chunk ends without a byte");

endmodule

### dv/qoi_image_stream_decoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QOI stream decoder testbench
// Feeds QOI files byte by byte, some well formed and some broken, and
// compares every header result and decoded pixel with a cycle-free decoder
// model kept in the bench. Stream length and idling change between phases.
// ----------------------------------------------------------------------------
module qoi_image_stream_decoder_core_test;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_OPCODE,
    ST_BODY,
    ST_IDLE
  } parse_state_e;

  localparam longint CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qoi_dec_in_if  in_ch ();
  qoi_dec_out_if out_ch ();
  qoi_dec_cfg_if cfg_ch ();

  qoi_image_stream_decoder_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  qoi_dec_pkg::item_t   byte_queue[$];
  qoi_dec_pkg::result_t pixel_queue[$];
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      bytes_pushed;
  int      errors = 0;
  longint  cycles = 0;
  bit      in_took = 1'b0;

  // Decoder model state.
  logic [31:0]  stream_len = '0;
  parse_state_e state = ST_HEADER;
  logic [7:0]   hdr[qoi_dec_pkg::HeaderBytes];
  logic [31:0]  seen = '0;
  logic [31:0]  left = '0;
  logic [7:0]   px[4] = '{8'd0, 8'd0, 8'd0, 8'd255};
  logic [7:0]   cidx[64][4] = '{default: 8'd0};
  logic [7:0]   op = '0;
  int           body_left = 0;

  function automatic void add_result(logic [1:0] kind, logic [14:0] w, logic [14:0] h,
                                     logic [7:0] ch, logic [1:0] err, bit last,
                                     bit done);
    qoi_dec_pkg::result_t r;
    r.kind = kind;
    r.red = (kind == qoi_dec_pkg::KIND_PIXEL) ? px[0] : 8'd0;
    r.green = (kind == qoi_dec_pkg::KIND_PIXEL) ? px[1] : 8'd0;
    r.blue = (kind == qoi_dec_pkg::KIND_PIXEL) ? px[2] : 8'd0;
    r.alpha = (kind == qoi_dec_pkg::KIND_PIXEL) ? px[3] : 8'd0;
    r.image_width = w;
    r.image_height = h;
    r.file_channels = ch;
    r.error_code = err;
    r.last_of_run = last;
    r.image_done = done;
    pixel_queue.push_back(r);
  endfunction

  function automatic void finish_chunk();
    int unsigned hash, run, count;
    hash = (px[0] * 3 + px[1] * 5 + px[2] * 7 + px[3] * 11) % 64;
    cidx[hash] = px;
    run = 1;
    if (op[7:6] == qoi_dec_pkg::TAG_RUN && op != qoi_dec_pkg::OP_RGB
        && op != qoi_dec_pkg::OP_RGBA) run = op[5:0] + 1;
    count = (run < left) ? run : left;
    for (int unsigned k = 0; k < count; k++) begin
      left--;
      add_result(qoi_dec_pkg::KIND_PIXEL, '0, '0, '0, qoi_dec_pkg::ERR_NONE,
                 k + 1 == count, left == 0);
    end
    state = (left != 0) ? ST_OPCODE : ST_IDLE;
  endfunction

  function automatic void judge_header();
    logic [31:0] w, h;
    logic [1:0]  err;
    w = {hdr[4], hdr[5], hdr[6], hdr[7]};
    h = {hdr[8], hdr[9], hdr[10], hdr[11]};
    err = qoi_dec_pkg::ERR_NONE;
    if ({hdr[0], hdr[1], hdr[2], hdr[3]} != 32'h716f6966) err = qoi_dec_pkg::ERR_MAGIC;
    else if (w == 0 || h == 0 || w > 16384 || h > 16384) err = qoi_dec_pkg::ERR_DIM;
    else if (hdr[12] != 8'd3 && hdr[12] != 8'd4) err = qoi_dec_pkg::ERR_CHANNELS;
    if (err != qoi_dec_pkg::ERR_NONE) begin
      state = ST_IDLE;
      add_result(qoi_dec_pkg::KIND_HDR_BAD, '0, '0, hdr[12], err, 1'b1, 1'b0);
    end else begin
      state = ST_OPCODE;
      left = w * h;
      add_result(qoi_dec_pkg::KIND_HDR_OK, w[14:0], h[14:0], hdr[12],
                 qoi_dec_pkg::ERR_NONE, 1'b1, 1'b0);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic sos);
    logic [31:0] pos;
    logic [7:0]  vg;
    int          total;
    if (sos) begin
      state = ST_HEADER;
      seen = '0;
      left = '0;
      px = '{8'd0, 8'd0, 8'd0, 8'd255};
      foreach (cidx[i]) cidx[i] = '{8'd0, 8'd0, 8'd0, 8'd0};
      op = '0;
      body_left = 0;
    end
    pos = seen;
    if (seen != 32'hFFFFFFFF) seen++;
    case (state)
      ST_HEADER: begin
        if (pos < qoi_dec_pkg::HeaderBytes) begin
          hdr[pos] = b;
          if (pos == qoi_dec_pkg::HeaderBytes - 1) judge_header();
        end
      end
      ST_OPCODE: begin
        if ({32'd0, pos} + 64'd8 >= {32'd0, stream_len}) begin
          state = ST_IDLE;
        end else begin
          op = b;
          if (b == qoi_dec_pkg::OP_RGB || b == qoi_dec_pkg::OP_RGBA) begin
            body_left = (b == qoi_dec_pkg::OP_RGB) ? 3 : 4;
            state = ST_BODY;
          end else if (b[7:6] == qoi_dec_pkg::TAG_LUMA) begin
            body_left = 1;
            state = ST_BODY;
          end else begin
            if (b[7:6] == qoi_dec_pkg::TAG_INDEX) px = cidx[b[5:0]];
            else if (b[7:6] == qoi_dec_pkg::TAG_DIFF) begin
              px[0] = px[0] + b[5:4] - 8'd2;
              px[1] = px[1] + b[3:2] - 8'd2;
              px[2] = px[2] + b[1:0] - 8'd2;
            end
            finish_chunk();
          end
        end
      end
      ST_BODY: begin
        if (op == qoi_dec_pkg::OP_RGB || op == qoi_dec_pkg::OP_RGBA) begin
          total = (op == qoi_dec_pkg::OP_RGB) ? 3 : 4;
          px[total - body_left] = b;
        end else begin
          vg = {2'b00, op[5:0]} - 8'd32;
          px[0] = px[0] + vg - 8'd8 + b[7:4];
          px[1] = px[1] + vg;
          px[2] = px[2] + vg - 8'd8 + b[3:0];
        end
        if (body_left > 0) body_left--;
        if (body_left == 0) finish_chunk();
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Input driver and output ready, both changed at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(in_ch.valid && !in_took)) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.payload <= byte_queue[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: model update on each input transfer, check on each output transfer.
  always @(posedge clk_i) begin
    qoi_dec_pkg::item_t   it;
    qoi_dec_pkg::result_t got, want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      in_took = in_ch.valid && in_ch.ready;
      if (in_took) begin
        it = byte_queue.pop_front();
        decode_byte(it.data_byte, it.start_of_image);
      end
      if (cfg_ch.valid && cfg_ch.ready) stream_len = cfg_ch.payload;
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (pixel_queue.size() == 0) begin
          $error("unexpected result transfer: kind %0d", got.kind);
          errors++;
        end else begin
          want = pixel_queue.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("alpha", want.alpha, got.alpha);
          check_field("image_width", want.image_width, got.image_width);
          check_field("image_height", want.image_height, got.image_height);
          check_field("file_channels", want.file_channels, got.file_channels);
          check_field("error_code", want.error_code, got.error_code);
          check_field("last_of_run", want.last_of_run, got.last_of_run);
          check_field("image_done", want.image_done, got.image_done);
        end
      end
    end
  end

  task automatic push_byte(logic [7:0] b, logic sos = 1'b0);
    qoi_dec_pkg::item_t it;
    it.data_byte = b;
    it.start_of_image = sos;
    byte_queue.push_back(it);
    bytes_pushed++;
  endtask

  task automatic push_header(logic [31:0] w, logic [31:0] h, logic [7:0] ch,
                             bit good_magic, logic sos);
    logic [7:0] m[4] = '{8'h71, 8'h6f, 8'h69, 8'h66};
    if (!good_magic) m[$urandom_range(3)] ^= 8'd1 << $urandom_range(7);
    push_byte(m[0], sos);
    for (int i = 1; i < 4; i++) push_byte(m[i]);
    for (int i = 3; i >= 0; i--) push_byte(w[i*8 +: 8]);
    for (int i = 3; i >= 0; i--) push_byte(h[i*8 +: 8]);
    push_byte(ch);
    push_byte(8'($urandom_range(255)));
  endtask

  task automatic push_chunk();
    case ($urandom_range(5))
      0: push_byte({qoi_dec_pkg::TAG_INDEX, 6'($urandom_range(63))});
      1: push_byte({qoi_dec_pkg::TAG_DIFF, 6'($urandom_range(63))});
      2: begin
        push_byte({qoi_dec_pkg::TAG_LUMA, 6'($urandom_range(63))});
        push_byte(8'($urandom_range(255)));
      end
      3: begin
        push_byte(qoi_dec_pkg::OP_RGB);
        repeat (3) push_byte(8'($urandom_range(255)));
      end
      4: begin
        push_byte(qoi_dec_pkg::OP_RGBA);
        repeat (4) push_byte(8'($urandom_range(255)));
      end
      default: push_byte({qoi_dec_pkg::TAG_RUN, 6'($urandom_range(61))});
    endcase
  endtask

  task automatic push_random_file();
    logic [31:0] w, h;
    logic [7:0]  ch;
    int          mode;
    mode = $urandom_range(11);
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 6);
    ch = 8'($urandom_range(3, 4));
    case (mode)
      0: push_header(w, h, ch, 1'b0, 1'b1);
      1: begin
        case ($urandom_range(3))
          0: w = 0;
          1: h = 0;
          2: w = $urandom_range(16385, 32'hFFFFFFFF);
          default: begin
            w = 16384;
            h = 16385;
          end
        endcase
        push_header(w, h, ch, 1'b1, 1'b1);
      end
      2: begin
        do ch = 8'($urandom_range(255)); while (ch == 3 || ch == 4);
        push_header(w, h, ch, 1'b1, 1'b1);
      end
      3: push_header(32'd16384, ($urandom_range(1, 2) == 1) ? 32'd1 : 32'd16384, ch,
                     1'b1, 1'b1);
      default: push_header(w, h, ch, 1'b1, 1'b1);
    endcase
    repeat ($urandom_range(1, 10)) push_chunk();
    // Trailing noise, ignored by a finished or rejected file.
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic write_stream_len(logic [31:0] v);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (byte_queue.size() != 0 || pixel_queue.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] lens[5] = '{32'hFFFFFFFF, 32'd0, 32'd23, 32'd60, 32'hFFFFFFFF};
    int          idle_pct[5] = '{0, 75, 0, 6, 0};
    int          stall_tab[5] = '{0, 0, 75, 6, 0};
    int          target[5] = '{0, 15, 25, 45, 55};
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < 5; p++) begin
      write_stream_len(lens[p]);
      send_idle_pct = idle_pct[p];
      stall_pct = stall_tab[p];
      bytes_pushed = 0;
      if (p == 0) begin
        // A file with no start marker, counted from reset: every chunk type,
        // then a run longer than the pixels left and a byte after the end.
        push_header(32'd3, 32'd4, 8'd4, 1'b1, 1'b0);
        push_byte(qoi_dec_pkg::OP_RGBA);
        push_byte(8'h10); push_byte(8'h20); push_byte(8'h30); push_byte(8'h40);
        push_byte(qoi_dec_pkg::OP_RGB); push_byte(8'hFF); push_byte(8'h00); push_byte(8'h80);
        push_byte(8'h40); push_byte(8'h7F);
        push_byte(8'h80); push_byte(8'h00);
        push_byte(8'hBF); push_byte(8'hFF);
        push_byte(8'h00); push_byte(8'h3F);
        push_byte(8'hFD);
        push_byte(8'h55);
      end else begin
        while (bytes_pushed < target[p]) push_random_file();
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
src/qoi_dec_pkg.sv
src/qoi_dec_if.sv
src/qoi_dec_ctrl.sv
src/qoi_dec_dp.sv
src/qoi_image_stream_decoder_core.sv
dv/qoi_image_stream_decoder_core_test.sv
